// ===== sv/tdrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdrc_pkg;

    // Sequencer states of the divisor search.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_DECIDE,
        ST_START,
        ST_WAIT,
        ST_TEST,
        ST_FINISH
    } t_state;

    // Ranges up to this many divisors are scanned one by one. Wider ranges
    // pair each small divisor with its cofactor instead.
    localparam int SCAN_LIMIT = 65536;

endpackage

`default_nettype wire

// ===== sv/tdrc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that produces one quotient bit per cycle.
module tdrc_div #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_quotient,
    output logic [VALUE_WIDTH-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;

    assign shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(VALUE_WIDTH);
        end else if (r_busy) begin
            // The trial subtraction fits whenever its sign bit is clear.
            if (!diff[VALUE_WIDTH]) begin
                r_rem <= diff[VALUE_WIDTH-1:0];
            end else begin
                r_rem <= shifted[VALUE_WIDTH-1:0];
            end
            r_quo <= {r_quo[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done      = r_busy && (r_cnt == CNT_W'(1));
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== sv/trial_division_range_check.sv =====
// A zero candidate or a range empty as given finishes straight from ST_CLIP, a range
// that clipping to the candidate empties finishes from ST_DECIDE, and otherwise the
// search runs k trial divisions, where k is at most the range size up to 65536
// divisors and at most floor(sqrt(candidate)) + 1 for wider ranges.
// Items are taken one at a time; a stalled result stops the next item in ST_FINISH.
// Reset is synchronous and active low; it clears the sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

// Trial division over a half-open divisor range.
//
// Each accepted item is clipped first: a lower bound of zero becomes one,
// because a zero divisor never counts, and divisors above the candidate are
// dropped, because they can never divide it. An empty range reports not
// divisible, and a zero candidate is divided by every nonzero divisor.
//
// A narrow range is scanned one divisor at a time, stopping at the first
// zero remainder. A wide range instead walks q upward from one while q does
// not exceed candidate / q; every divisor of the candidate is either such a
// q or the cofactor candidate / q, so the range is hit exactly when one of
// the two lies in it for a zero remainder.
//
// All divisions share one restoring divider that retires one quotient bit
// per cycle; each trial is started in ST_START, waited on in ST_WAIT until
// the divider is done, and has its outcome tested in ST_TEST.
module trial_division_range_check #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_candidate,
    input  wire logic [VALUE_WIDTH-1:0] i_lower_divisor,
    input  wire logic [VALUE_WIDTH-1:0] i_upper_divisor,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_divisible
);

    localparam int CMP_W = (VALUE_WIDTH + 1 > 17) ? VALUE_WIDTH + 1 : 17;

    tdrc_pkg::t_state r_state;
    tdrc_pkg::t_state n_state;

    // The upper bound and the current divisor carry one extra bit, since the
    // clipped upper bound can be candidate + 1.
    logic [VALUE_WIDTH-1:0] r_cand;
    logic [VALUE_WIDTH-1:0] r_lo;
    logic [VALUE_WIDTH:0]   r_hi;
    logic [VALUE_WIDTH:0]   r_d;
    logic                   r_scan;
    logic                   r_result;
    logic                   r_out_valid;
    logic                   r_out_bit;

    logic                   in_accept;
    logic                   slot_free;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;

    logic [VALUE_WIDTH-1:0] lo_fixed;
    logic [VALUE_WIDTH:0]   cand_ext;
    logic                   clip_empty;
    logic                   cand_zero;
    logic                   hi_above;
    logic                   range_empty;
    logic [VALUE_WIDTH:0]   span;
    logic                   scan_fits;
    logic [VALUE_WIDTH:0]   d_next;
    logic                   rem_zero;
    logic                   scan_last;
    logic                   past_root;
    logic                   q_in_range;
    logic                   cof_in_range;
    logic                   test_hit;
    logic                   test_miss;

    tdrc_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cand),
        .i_divisor  (r_d[VALUE_WIDTH-1:0]),
        .o_done     (div_done),
        .o_quotient (quot),
        .o_remainder(rem)
    );

    // Range checks and loop decisions shared by the next state logic and
    // the datapath registers.
    always_comb begin
        lo_fixed     = (r_lo == '0) ? VALUE_WIDTH'(1) : r_lo;
        cand_ext     = {1'b0, r_cand};
        clip_empty   = {1'b0, lo_fixed} >= r_hi;
        cand_zero    = (r_cand == '0);
        hi_above     = r_hi > cand_ext;
        range_empty  = {1'b0, r_lo} >= r_hi;
        span         = r_hi - {1'b0, r_lo};
        scan_fits    = CMP_W'(span) <= CMP_W'(tdrc_pkg::SCAN_LIMIT);
        d_next       = r_d + (VALUE_WIDTH + 1)'(1);
        rem_zero     = (rem == '0);
        scan_last    = d_next >= r_hi;
        past_root    = r_d > {1'b0, quot};
        q_in_range   = (r_d[VALUE_WIDTH-1:0] >= r_lo) && (r_d < r_hi);
        cof_in_range = (quot != '0) && (quot >= r_lo) && ({1'b0, quot} < r_hi);
        if (r_scan) begin
            test_hit  = rem_zero;
            test_miss = !rem_zero && scan_last;
        end else begin
            test_hit  = !past_root && rem_zero && (q_in_range || cof_in_range);
            test_miss = past_root;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdrc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = tdrc_pkg::ST_CLIP;
                end
            end
            tdrc_pkg::ST_CLIP: begin
                if (clip_empty || cand_zero) begin
                    n_state = tdrc_pkg::ST_FINISH;
                end else begin
                    n_state = tdrc_pkg::ST_DECIDE;
                end
            end
            tdrc_pkg::ST_DECIDE: begin
                if (range_empty) begin
                    n_state = tdrc_pkg::ST_FINISH;
                end else begin
                    n_state = tdrc_pkg::ST_START;
                end
            end
            tdrc_pkg::ST_START: begin
                n_state = tdrc_pkg::ST_WAIT;
            end
            tdrc_pkg::ST_WAIT: begin
                if (div_done) begin
                    n_state = tdrc_pkg::ST_TEST;
                end
            end
            tdrc_pkg::ST_TEST: begin
                if (test_hit || test_miss) begin
                    n_state = tdrc_pkg::ST_FINISH;
                end else begin
                    n_state = tdrc_pkg::ST_START;
                end
            end
            tdrc_pkg::ST_FINISH: begin
                if (slot_free) begin
                    n_state = tdrc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdrc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != tdrc_pkg::ST_IDLE);
        div_start  = (r_state == tdrc_pkg::ST_START);
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers. The clipped bounds are written back in place so
    // the search loop only ever sees a nonempty range within the candidate.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tdrc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    r_cand <= i_candidate;
                    r_lo   <= i_lower_divisor;
                    r_hi   <= {1'b0, i_upper_divisor};
                end
            end
            tdrc_pkg::ST_CLIP: begin
                r_lo     <= lo_fixed;
                r_result <= !clip_empty && cand_zero;
                if (hi_above) begin
                    r_hi <= cand_ext + (VALUE_WIDTH + 1)'(1);
                end
            end
            tdrc_pkg::ST_DECIDE: begin
                r_result <= 1'b0;
                r_scan   <= scan_fits;
                if (scan_fits) begin
                    r_d <= {1'b0, r_lo};
                end else begin
                    r_d <= (VALUE_WIDTH + 1)'(1);
                end
            end
            tdrc_pkg::ST_TEST: begin
                r_result <= test_hit;
                r_d      <= d_next;
            end
            tdrc_pkg::ST_START, tdrc_pkg::ST_WAIT, tdrc_pkg::ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: the finished result waits here while the next item
    // is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == tdrc_pkg::ST_FINISH) && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == tdrc_pkg::ST_FINISH) && slot_free) begin
            r_out_bit <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_divisible = r_out_bit;

endmodule

`default_nettype wire

// ===== sv/tdrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdrc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_divisible
);

    // Once an item is taken, the input side is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after an accept");

    // A result only appears after an item was in flight.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no item in flight");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_divisible))
        else $error("output payload changed while stalled");

endmodule

bind trial_division_range_check tdrc_checker u_tdrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_divisible(o_divisible)
);

`default_nettype wire

// ===== sim/trial_division_range_check_checker.sv =====
`timescale 1ns / 1ps

module trial_division_range_check_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_candidate,
    input  wire logic [VALUE_WIDTH-1:0] i_lower_divisor,
    input  wire logic [VALUE_WIDTH-1:0] i_upper_divisor,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic                   i_divisible,
    output int                          o_fail_count,
    output int                          o_pending
);

    // Ranges up to this many divisors are scanned directly; wider ones are
    // searched by pairing each small divisor with its cofactor.
    localparam longint unsigned SCAN_SPAN = 65536;

    typedef struct {
        logic [VALUE_WIDTH-1:0] candidate;
        logic [VALUE_WIDTH-1:0] lower_divisor;
        logic [VALUE_WIDTH-1:0] upper_divisor;
        logic                   divisible;
    } t_verdict;

    t_verdict expected_verdicts[$];
    int       mismatches = 0;

    assign o_fail_count = mismatches;

    // True when some nonzero divisor in [lower, upper) leaves no remainder.
    function automatic logic range_has_divisor(input logic [VALUE_WIDTH-1:0] cand,
                                               input logic [VALUE_WIDTH-1:0] lower,
                                               input logic [VALUE_WIDTH-1:0] upper);
        longint unsigned c;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned d;
        longint unsigned q;
        c  = 64'(cand);
        lo = 64'(lower);
        hi = 64'(upper);
        if (lo == 0) begin
            lo = 1;
        end
        if (lo >= hi) begin
            return 1'b0;
        end
        if (c == 0) begin
            return 1'b1;
        end
        if (hi > c) begin
            hi = c + 1;
        end
        if (lo >= hi) begin
            return 1'b0;
        end
        if (hi - lo <= SCAN_SPAN) begin
            for (d = lo; d < hi; d++) begin
                if (c % d == 0) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        for (q = 1; q <= c / q; q++) begin
            if (c % q == 0) begin
                if ((q >= lo && q < hi) || (c / q >= lo && c / q < hi)) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                want.candidate     = i_candidate;
                want.lower_divisor = i_lower_divisor;
                want.upper_divisor = i_upper_divisor;
                want.divisible     = range_has_divisor(i_candidate, i_lower_divisor,
                                                       i_upper_divisor);
                expected_verdicts.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result %b with no item outstanding",
                                              i_divisible));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_divisible !== want.divisible) begin
                        report_mismatch($sformatf(
                            "candidate %0d range [%0d, %0d): divisible %b, want %b",
                            want.candidate, want.lower_divisor, want.upper_divisor,
                            i_divisible, want.divisible));
                    end
                end
            end
        end
        o_pending <= expected_verdicts.size();
    end

endmodule

// ===== sim/trial_division_range_check_tb.sv =====
`timescale 1ns / 1ps

module trial_division_range_check_tb;

    localparam int VALUE_WIDTH = 31;
    // One trial division spans the divider's run plus a start and a test state.
    localparam longint unsigned TRIAL_CYCLES = VALUE_WIDTH + 2;
    localparam longint unsigned SCAN_SPAN = 65536;
    // Random items whose worst-case trial count exceeds this are redrawn.
    localparam longint unsigned MAX_TRIALS = 520;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD = 2500;
    localparam int DRAIN_CYCLES = 4 * TRIAL_CYCLES + 20;
    localparam logic [VALUE_WIDTH-1:0] MAX_VALUE = '1;
    localparam logic [VALUE_WIDTH-1:0] TOP_BIT = 1 << (VALUE_WIDTH - 1);

    // Receiver stall patterns; each one runs for a random stretch of cycles.
    typedef enum logic [1:0] {
        FLOW_OPEN,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PULSED
    } flow_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [VALUE_WIDTH-1:0] candidate;
    logic [VALUE_WIDTH-1:0] lower_divisor;
    logic [VALUE_WIDTH-1:0] upper_divisor;
    logic                   out_valid;
    logic                   out_stall;
    logic                   divisible;
    int                     fail_count;
    int                     pending_results;

    // Bookkeeping used by the sender, the receiver and the watchdog.
    int                     items_accepted = 0;
    int                     burst_left = 0;
    longint unsigned        cycle_count = 0;
    longint unsigned        cycle_limit = 20000 + LONG_HOLD;

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    trial_division_range_check #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_candidate    (candidate),
        .i_lower_divisor(lower_divisor),
        .i_upper_divisor(upper_divisor),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_divisible    (divisible)
    );

    trial_division_range_check_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_candidate    (candidate),
        .i_lower_divisor(lower_divisor),
        .i_upper_divisor(upper_divisor),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_divisible    (divisible),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // Upper bound on the number of trial divisions an item can cost. It follows
    // the block's own clipping: a zero lower bound counts as one, divisors above
    // the candidate are dropped, narrow ranges are scanned one divisor at a time,
    // and wide ranges walk the divisors up to the square root of the candidate.
    // A wide range that reaches past the candidate contains the candidate itself,
    // so its very first pairing already hits.
    function automatic longint unsigned trial_bound(input logic [VALUE_WIDTH-1:0] cand,
                                                    input logic [VALUE_WIDTH-1:0] lower,
                                                    input logic [VALUE_WIDTH-1:0] upper);
        longint unsigned c;
        longint unsigned lo;
        longint unsigned hi;
        c  = cand;
        lo = lower;
        hi = upper;
        if (lo == 0) begin
            lo = 1;
        end
        if (lo >= hi || c == 0) begin
            return 0;
        end
        if (hi > c) begin
            hi = c + 1;
        end
        if (lo >= hi) begin
            return 0;
        end
        if (hi - lo <= SCAN_SPAN) begin
            return hi - lo;
        end
        if (upper > cand) begin
            return 1;
        end
        return longint'($sqrt(real'(c))) + 2;
    endfunction

    // Offers one item and returns at the clock edge where it is accepted. Items
    // go out in bursts of random length; a random gap may open each burst, and
    // within a burst valid stays high while the fields move to the next item.
    task automatic offer_item(input logic [VALUE_WIDTH-1:0] cand,
                              input logic [VALUE_WIDTH-1:0] lower,
                              input logic [VALUE_WIDTH-1:0] upper);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
            end
        end
        burst_left--;
        // Grow the watchdog limit by a generous multiple of this item's worst
        // case: all its trials, a full receiver stall stretch and a sender gap.
        cycle_limit += 4 * (3 + (trial_bound(cand, lower, upper) + 1) * TRIAL_CYCLES
                            + 320 + 13);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        candidate     <= cand;
        lower_divisor <= lower;
        upper_divisor <= upper;
        do begin
            @(posedge clk);
        end while (in_stall !== 1'b0);
        items_accepted++;
    endtask

    // The watchdog: a hung handshake or a runaway search ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver changes its stall pattern after each random run. At the first
    // pattern change after forty items have been accepted it holds off for a long
    // stretch while the sender keeps offering, so the block holds its result and
    // must stall its input.
    initial begin : receiver
        flow_mode_t mode;
        int         run_len;
        int         period;
        int         n;
        bit         held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            mode    = flow_mode_t'($urandom_range(0, 3));
            run_len = $urandom_range(20, 300);
            period  = $urandom_range(2, 9);
            if (!held && items_accepted >= 40) begin
                held = 1'b1;
                repeat (LONG_HOLD) @(negedge clk) out_stall <= 1'b1;
            end
            for (n = 0; n < run_len; n++) begin
                @(negedge clk);
                case (mode)
                    FLOW_OPEN: begin
                        out_stall <= 1'b0;
                    end
                    FLOW_LIGHT: begin
                        out_stall <= ($urandom_range(0, 99) < 30);
                    end
                    FLOW_HEAVY: begin
                        out_stall <= ($urandom_range(0, 99) < 75);
                    end
                    default: begin
                        out_stall <= ((n % period) < period / 2);
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [VALUE_WIDTH-1:0] c;
        logic [VALUE_WIDTH-1:0] lo;
        logic [VALUE_WIDTH-1:0] hi;
        longint unsigned        d;
        longint unsigned        m;
        int                     n;
        int                     pick;
        in_valid      = 1'b0;
        candidate     = '0;
        lower_divisor = '0;
        upper_divisor = '0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items. Small ranges with and without a divisor come first.
        offer_item(12, 2, 4);
        offer_item(13, 2, 13);
        offer_item(30, 7, 10);
        // A zero candidate is divided by any nonzero divisor, unless the range is empty.
        offer_item(0, 5, 6);
        offer_item(0, 7, 7);
        offer_item(0, 0, 1);
        offer_item(0, 0, MAX_VALUE);
        // A zero lower bound is skipped over, and a divisor of one always hits.
        offer_item(7, 0, 1);
        offer_item(7, 0, 2);
        offer_item(9, 0, 3);
        offer_item(1, 1, 2);
        // Divisors above the candidate are clipped away.
        offer_item(1, 2, 3);
        offer_item(5, 6, MAX_VALUE);
        offer_item(5, 3, MAX_VALUE);
        // Extremes of the fields; the largest value is prime.
        offer_item(MAX_VALUE, 1, 2);
        offer_item(MAX_VALUE, MAX_VALUE - 20, MAX_VALUE);
        offer_item(MAX_VALUE, MAX_VALUE, MAX_VALUE);
        offer_item(MAX_VALUE, MAX_VALUE, 0);
        offer_item(MAX_VALUE, 0, 0);
        offer_item(TOP_BIT, TOP_BIT - 5, TOP_BIT + 5);
        // Wide ranges: a hit through the candidate itself, through a small
        // divisor, through a cofactor, and a prime that has no hit at all.
        offer_item(MAX_VALUE - 1, 2, MAX_VALUE);
        offer_item(MAX_VALUE - 1, 2, MAX_VALUE - 1);
        offer_item(MAX_VALUE - 1, (MAX_VALUE - 1) / 2, (MAX_VALUE - 1) / 2 + 70000);
        offer_item(131072, 3, 131072);
        offer_item(131071, 2, 131071);

        // Random items. Most use narrow ranges so that the per-item search stays
        // short; products of a chosen divisor give hits far from zero, and a few
        // wide ranges exercise the cofactor search on moderate candidates.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            do begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    c  = $urandom();
                    lo = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom();
                    hi = lo + $urandom_range(0, 16);
                end else if (pick < 68) begin
                    d  = $urandom_range(2, 65535);
                    m  = $urandom_range(1, MAX_VALUE / d);
                    c  = d * m;
                    lo = d - $urandom_range(0, 6);
                    hi = d + $urandom_range(0, 6);
                end else if (pick < 82) begin
                    c  = $urandom_range(0, 80);
                    lo = $urandom_range(0, 90);
                    hi = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100) : $urandom();
                end else if (pick < 90) begin
                    c  = $urandom_range(1 << 20, MAX_VALUE - 1);
                    lo = $urandom_range(0, 1000);
                    hi = $urandom_range(c + 1, MAX_VALUE);
                end else if (pick < 93) begin
                    c  = $urandom_range(1 << 17, 1 << 18);
                    lo = $urandom_range(0, c / 4);
                    hi = lo + 65537 + $urandom_range(0, c - lo - 65537);
                end else begin
                    c  = $urandom();
                    lo = $urandom();
                    hi = $urandom();
                end
            end while (trial_bound(c, lo, hi) > MAX_TRIALS);
            offer_item(c, lo, hi);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tdrc_pkg.sv
sv/tdrc_div.sv
sv/trial_division_range_check.sv
sv/tdrc_checker.sv
sim/trial_division_range_check_checker.sv
sim/trial_division_range_check_tb.sv
